>>> rtl/core/pu16f_pkg.sv
// Shared types and constants for the packed 16-bit code to single-precision unpacker.
package pu16f_pkg;

    localparam int unsigned CFG_INDEX_W = 2;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_CODE_SHIFT     = 2'd0;
    localparam cfg_index_t CFG_OFFSET_MINIMUM = 2'd1;
    localparam cfg_index_t CFG_MAX_EXPONENT   = 2'd2;

    localparam logic [4:0]  CODE_SHIFT_RESET = 5'd0;
    localparam logic [31:0] OFFSET_RESET     = 32'd0;
    localparam logic [7:0]  MAX_EXP_RESET    = 8'd127;

    localparam logic [23:0] SAT_MAG = 24'hFFFFFF;
    localparam logic [7:0]  EXP_INF = 8'hFF;

    typedef struct packed {
        logic [4:0]  code_shift;
        logic [31:0] offset_minimum;
        logic [7:0]  max_exponent;
    } cfg_t;

    typedef struct packed {
        logic        sign;
        logic [23:0] mag;
        logic        last;
    } mag_beat_t;

endpackage

>>> rtl/core/pu16f_in_if.sv
// Input channel carrying one packed code and its last flag per beat.
interface pu16f_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] packed_code;
    logic        last_in;

    modport source (output valid, output packed_code, output last_in, input ready);
    modport sink (input valid, input packed_code, input last_in, output ready);
endinterface

>>> rtl/core/pu16f_out_if.sv
// Output channel carrying one single-precision bit pattern and its last flag per beat.
interface pu16f_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] float_bits;
    logic        last_out;

    modport source (output valid, output float_bits, output last_out, input ready);
    modport sink (input valid, input float_bits, input last_out, output ready);
endinterface

>>> rtl/core/pu16f_mag.sv
// First stage: shift and offset the code, take the saturated magnitude and sign.
module pu16f_mag (
    input  logic                  clk,
    input  logic                  rst_n,
    pu16f_in_if.sink              in_ch,
    input  pu16f_pkg::cfg_t       cfg,
    output logic                  mag_valid,
    input  logic                  mag_ready,
    output pu16f_pkg::mag_beat_t  mag_beat
);
    import pu16f_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    mag_beat_t   beat_reg;
    mag_beat_t   beat_next;
    logic        stage_ready;
    logic        take;
    logic [31:0] shifted;
    logic [31:0] sum;
    logic [31:0] abs_val;

    assign stage_ready = !valid_reg || mag_ready;
    assign take        = in_ch.valid && stage_ready;
    assign in_ch.ready = stage_ready;

    always_comb
    begin
        shifted = {16'd0, in_ch.packed_code} << cfg.code_shift;
        sum     = shifted + cfg.offset_minimum;
        abs_val = sum[31] ? (32'd0 - sum) : sum;
        beat_next.sign = sum[31];
        beat_next.mag  = (abs_val[31:24] != 8'd0) ? SAT_MAG : abs_val[23:0];
        beat_next.last = in_ch.last_in;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (mag_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            beat_reg <= beat_next;
        end
    end

    assign mag_valid = valid_reg;
    assign mag_beat  = beat_reg;

    // A negative value always has a nonzero magnitude.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && beat_reg.sign) |-> (beat_reg.mag != 24'd0))
        else $error("negative beat with zero magnitude");

    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> valid_reg)
        else $error("accepted beat not held in the magnitude stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !mag_ready) |=> valid_reg)
        else $error("stalled magnitude beat lost");
endmodule

>>> rtl/core/pu16f_enc.sv
// Second stage: normalise the magnitude and assemble the single-precision pattern.
module pu16f_enc (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            max_exponent,
    input  logic                  mag_valid,
    output logic                  mag_ready,
    input  pu16f_pkg::mag_beat_t  mag_beat,
    pu16f_out_if.source           out_ch
);
    import pu16f_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [31:0]       float_reg;
    logic              last_reg;
    logic [31:0]       float_next;
    logic              stage_ready;
    logic              take;
    logic [4:0]        lead;
    logic signed [9:0] exp_sum;
    logic [23:0]       norm;
    logic [23:0]       sub_field;

    function automatic logic [4:0] lead_pos(input logic [23:0] m);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (m[i])
            begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

    assign stage_ready = !valid_reg || out_ch.ready;
    assign take        = mag_valid && stage_ready;
    assign mag_ready   = stage_ready;

    always_comb
    begin
        lead      = lead_pos(mag_beat.mag);
        exp_sum   = signed'({2'b00, max_exponent}) + signed'({5'd0, lead}) - 10'sd23;
        norm      = mag_beat.mag << (5'd23 - lead);
        sub_field = mag_beat.mag << (max_exponent - 8'd1);
        if (mag_beat.mag == 24'd0)
        begin
            float_next = 32'd0;
        end
        else if (max_exponent == 8'd0)
        begin
            float_next = {mag_beat.sign, 8'd0, mag_beat.mag[22:0]};
        end
        else if (exp_sum >= 10'sd255)
        begin
            float_next = {mag_beat.sign, EXP_INF, 23'd0};
        end
        else if (exp_sum >= 10'sd1)
        begin
            float_next = {mag_beat.sign, exp_sum[7:0], norm[22:0]};
        end
        else
        begin
            float_next = {mag_beat.sign, 8'd0, sub_field[22:0]};
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            float_reg <= float_next;
            last_reg  <= mag_beat.last;
        end
    end

    assign out_ch.valid      = valid_reg;
    assign out_ch.float_bits = float_reg;
    assign out_ch.last_out   = last_reg;

    // The all-ones exponent is only ever produced as an infinity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && float_reg[30:23] == EXP_INF) |-> (float_reg[22:0] == 23'd0))
        else $error("NaN pattern produced");

    // A zero value gives positive zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && mag_beat.mag == 24'd0) |=> (float_reg == 32'd0))
        else $error("zero value not encoded as positive zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (valid_reg && float_reg[31] == $past(mag_beat.sign)))
        else $error("sign lost in the encode stage");
endmodule

>>> rtl/core/packed_u16_to_float_unpack_top.sv
// Top level of the packed 16-bit code to single-precision unpacker.
//
// Each input beat carries one unsigned 16-bit code and a last flag. The code is
// shifted left by the code shift register, the signed offset is added in 32-bit
// wrapping arithmetic, the magnitude is saturated at 24 bits and the result is
// sent as a single-precision bit pattern scaled by the maximum exponent register.
// The last flag travels with its beat unchanged.
// The block is a two-stage pipeline: a magnitude stage, then an encode stage,
// each with its own registered beat. One beat is taken in every cycle while
// the receiver keeps up, and each result leaves in the order its beat came in.
// When the receiver stalls, the registered results are held and input ready falls
// once both stages are full; no beat is lost or repeated.
// Reset clears both stages and loads the registers with shift zero, offset zero
// and maximum exponent 127. Registers are written through the write port at any
// edge with the write enable high; they should only change while the pipeline
// is empty.
module packed_u16_to_float_unpack_top (
    input  logic                    clk,
    input  logic                    rst_n,
    pu16f_in_if.sink                in_ch,
    pu16f_out_if.source             out_ch,
    input  logic                    cfg_we,
    input  pu16f_pkg::cfg_index_t   cfg_index,
    input  logic [31:0]             cfg_wdata
);
    import pu16f_pkg::*;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    logic      mag_valid;
    logic      mag_ready;
    mag_beat_t mag_beat;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CODE_SHIFT:     cfg_next.code_shift     = cfg_wdata[4:0];
                CFG_OFFSET_MINIMUM: cfg_next.offset_minimum = cfg_wdata;
                CFG_MAX_EXPONENT:   cfg_next.max_exponent   = cfg_wdata[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_shift     <= CODE_SHIFT_RESET;
            cfg_reg.offset_minimum <= OFFSET_RESET;
            cfg_reg.max_exponent   <= MAX_EXP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pu16f_mag u_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg_reg),
        .mag_valid (mag_valid),
        .mag_ready (mag_ready),
        .mag_beat  (mag_beat)
    );

    pu16f_enc u_enc (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_exponent (cfg_reg.max_exponent),
        .mag_valid    (mag_valid),
        .mag_ready    (mag_ready),
        .mag_beat     (mag_beat),
        .out_ch       (out_ch)
    );
endmodule
